// ===== rtl/pktq_pkg.sv =====
// ----------------------------------------------------------------------------
// pktq_pkg
// Shared types and constants of the packet ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pktq_pkg;

  localparam int DEF_MAX_SLOTS = 8;
  localparam int DEF_PKT_BYTES = 16;

  // widest slot index, packet length and byte address over the parameter range
  localparam int SLOT_W = 6;
  localparam int LEN_W  = 7;
  localparam int ADDR_W = 12;

  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_PEEK  = 3'd2;
  localparam logic [2:0] MODE_DROP  = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  localparam logic [1:0] ADDR_SLOTS_IN_USE = 2'd0;
  localparam logic [3:0] SLOTS_IN_USE_RST  = 4'd8;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic [7:0] max_len;
  } pktq_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] byte_out;
    logic [4:0] length;
    logic [3:0] depth;
    logic       status;
    logic       final_res;
  } pktq_res_t;

  // command handed from front to back
  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [3:0]        depth;
    logic              status;
    logic              stream;   // pop/peek that returns bytes
  } pktq_cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } pktq_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pktq_front.sv =====
// ----------------------------------------------------------------------------
// pktq_front
// Takes requests, keeps ring pointers and packet state, writes pushed bytes
// and issues one command per request that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module pktq_front import pktq_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int PKT_BYTES = DEF_PKT_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire pktq_item_t item_i,
  input  wire logic [3:0] slots_i,
  input  wire logic       clr_i,
  output logic            enq_o,
  output pktq_cmd_t       cmd_o,
  output logic [SLOT_W-1:0] head_o,
  output pktq_wr_t        wr_o
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(PKT_BYTES + 1);
  localparam int AW = $clog2(MAX_SLOTS * PKT_BYTES);

  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic          full_q, full_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rej_q, rej_d;
  logic [CW-1:0] slot_len_q [MAX_SLOTS];

  logic [IW:0]   rs, head_inc, tail_inc, depth;
  logic [IW-1:0] head_adv, tail_adv;
  logic          rej_now, store, commit;
  logic [CW-1:0] cnt_new, sl, rd_len;
  logic [AW-1:0] wr_addr;

  always_comb begin
    if (slots_i == 4'd0) begin
      rs = (IW+1)'(1);
    end else if (32'(slots_i) > MAX_SLOTS) begin
      rs = (IW+1)'(MAX_SLOTS);
    end else begin
      rs = (IW+1)'(slots_i);
    end
    head_inc = {1'b0, head_q} + (IW+1)'(1);
    tail_inc = {1'b0, tail_q} + (IW+1)'(1);
    head_adv = (head_inc >= rs) ? '0 : head_inc[IW-1:0];
    tail_adv = (tail_inc >= rs) ? '0 : tail_inc[IW-1:0];
    if (full_q) begin
      depth = rs;
    end else if (head_q >= tail_q) begin
      depth = {1'b0, head_q} - {1'b0, tail_q};
    end else begin
      depth = {1'b0, head_q} + rs - {1'b0, tail_q};
    end
  end

  always_comb begin
    rej_now = rej_q || (cnt_q == '0 && full_q);
    store   = !rej_now && item_i.has_byte && (32'(cnt_q) < PKT_BYTES);
    cnt_new = cnt_q + CW'(store);
    wr_addr = AW'(head_q) * AW'(PKT_BYTES) + AW'(cnt_q);
    sl      = slot_len_q[tail_q];
    if (16'(item_i.max_len) < 16'(sl)) begin
      rd_len = CW'(item_i.max_len);
    end else begin
      rd_len = sl;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    full_d = full_q;
    cnt_d  = cnt_q;
    rej_d  = rej_q;
    commit = 1'b0;
    enq_o  = 1'b0;
    cmd_o  = '0;
    cmd_o.kind  = item_i.mode;
    cmd_o.slot  = SLOT_W'(tail_q);
    wr_o.en     = 1'b0;
    wr_o.addr   = ADDR_W'(wr_addr);
    wr_o.data   = item_i.data_byte;
    if (clr_i) begin
      head_d = '0;
      tail_d = '0;
      full_d = 1'b0;
      cnt_d  = '0;
      rej_d  = 1'b0;
    end else if (acc_i) begin
      case (item_i.mode)
        MODE_PUSH: begin
          wr_o.en = store;
          if (item_i.last) begin
            enq_o = 1'b1;
            cnt_d = '0;
            rej_d = 1'b0;
            if (rej_now) begin
              cmd_o.status = 1'b1;
            end else begin
              commit    = 1'b1;
              cmd_o.len = LEN_W'(cnt_new);
              head_d    = head_adv;
              full_d    = (head_adv == tail_q);
            end
          end else begin
            cnt_d = cnt_new;
            rej_d = rej_now;
          end
        end
        MODE_POP, MODE_PEEK, MODE_DROP: begin
          enq_o = 1'b1;
          if (depth == '0) begin
            cmd_o.status = 1'b1;
          end else begin
            if (item_i.mode != MODE_DROP) begin
              cmd_o.len    = LEN_W'(rd_len);
              cmd_o.stream = (rd_len != '0);
            end
            if (item_i.mode != MODE_PEEK) begin
              tail_d = tail_adv;
              full_d = 1'b0;
            end
          end
        end
        MODE_QUERY: begin
          enq_o       = 1'b1;
          cmd_o.depth = 4'(depth);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      full_q <= 1'b0;
      cnt_q  <= '0;
      rej_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      full_q <= full_d;
      cnt_q  <= cnt_d;
      rej_q  <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      slot_len_q[head_q] <= cnt_new;
    end
  end

  assign head_o = SLOT_W'(head_q);

endmodule

`default_nettype wire

// ===== rtl/pktq_queue.sv =====
// ----------------------------------------------------------------------------
// pktq_queue
// Two-entry command queue between front and back, with a check of pending
// byte reads against a slot.
// ----------------------------------------------------------------------------
`default_nettype none

module pktq_queue import pktq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pktq_cmd_t         cmd_i,
  input  wire logic              pop_i,
  input  wire logic [SLOT_W-1:0] chk_slot_i,
  output logic                   valid_o,
  output pktq_cmd_t              cmd_o,
  output logic                   full_o,
  output logic                   hit_o
);

  pktq_cmd_t ent_q [2];
  logic [1:0] vld_q;
  logic       wp_q, rp_q;

  assign valid_o = vld_q[rp_q];
  assign cmd_o   = ent_q[rp_q];
  assign full_o  = &vld_q;
  // a pending read of the slot that a push would overwrite
  assign hit_o   = (vld_q[0] && ent_q[0].stream && ent_q[0].slot == chk_slot_i) ||
                   (vld_q[1] && ent_q[1].stream && ent_q[1].slot == chk_slot_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (pop_i) begin
        vld_q[rp_q] <= 1'b0;
        rp_q        <= ~rp_q;
      end
      if (push_i) begin
        vld_q[wp_q] <= 1'b1;
        wp_q        <= ~wp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pktq_back.sv =====
// ----------------------------------------------------------------------------
// pktq_back
// Holds the packet byte memory and turns commands into results, one per
// cycle while a command is queued, streaming bytes for pop and peek.
// ----------------------------------------------------------------------------
`default_nettype none

module pktq_back import pktq_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int PKT_BYTES = DEF_PKT_BYTES
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pktq_wr_t  wr_i,
  input  wire logic      valid_i,
  input  wire pktq_cmd_t cmd_i,
  output logic           deq_o,
  output logic           res_valid_o,
  output pktq_res_t      res_o
);

  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int IDX_W = $clog2(PKT_BYTES + 1);
  localparam int AW    = $clog2(MAX_SLOTS * PKT_BYTES);
  localparam int DEPTH = MAX_SLOTS * PKT_BYTES;

  logic [7:0]       mem_q [DEPTH];
  logic [7:0]       rdata_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             s1_valid_q, s1_byte_q;
  pktq_res_t        s1_res_q, res_d;
  logic             rd_en, fin;
  logic [AW-1:0]    rd_addr;

  always_comb begin
    rd_en   = valid_i && cmd_i.stream;
    fin     = !cmd_i.stream || (LEN_W'(idx_q) + LEN_W'(1) == cmd_i.len);
    deq_o   = valid_i && fin;
    rd_addr = AW'(cmd_i.slot[IW-1:0]) * AW'(PKT_BYTES) + AW'(idx_q);
    idx_d   = idx_q;
    if (rd_en) begin
      idx_d = fin ? '0 : idx_q + IDX_W'(1);
    end
    res_d.result_kind = cmd_i.kind;
    res_d.byte_out    = 8'd0;
    res_d.length      = 5'(cmd_i.len);
    res_d.depth       = cmd_i.depth;
    res_d.status      = cmd_i.status;
    res_d.final_res   = fin;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    s1_res_q  <= res_d;
    s1_byte_q <= cmd_i.stream;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      s1_valid_q <= valid_i;
    end
  end

  always_comb begin
    res_o = s1_res_q;
    if (s1_byte_q) begin
      res_o.byte_out = rdata_q;
    end
  end

  assign res_valid_o = s1_valid_q;

endmodule

`default_nettype wire

// ===== rtl/packet_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// packet_ring_queue_unit
// Ring of fixed-size packet slots with push, pop, peek, drop and depth query.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its command goes
// from the front through the queue to the back's result register; results
// come out at most one per cycle on result_valid_o and cannot be held off.
// A pop or peek returning bytes holds the back for one read of the packet
// memory per byte; other requests with a result give one. Between the two
// sits a two-entry command queue: busy is high while it is full, or while a
// queued byte read targets the slot that the next push would write. Push
// items without last give no result. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_ring_queue_unit import pktq_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int PKT_BYTES = DEF_PKT_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire pktq_item_t  item_i,
  output logic             result_valid_o,
  output pktq_res_t        result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0]        slots_q;
  logic              cfg_we, acc;
  logic              enq, q_valid, q_full, q_hit, deq;
  pktq_cmd_t         cmd_in, cmd_out;
  logic [SLOT_W-1:0] head;
  pktq_wr_t          wr;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_SLOTS_IN_USE);
  assign prdata = (paddr == ADDR_SLOTS_IN_USE) ? {28'd0, slots_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      slots_q <= pwdata[3:0];
    end
  end

  assign busy = q_full || q_hit;
  assign acc  = start && !busy;

  pktq_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .PKT_BYTES (PKT_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .item_i  (item_i),
    .slots_i (slots_q),
    .clr_i   (cfg_we),
    .enq_o   (enq),
    .cmd_o   (cmd_in),
    .head_o  (head),
    .wr_o    (wr)
  );

  pktq_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (enq),
    .cmd_i      (cmd_in),
    .pop_i      (deq),
    .chk_slot_i (head),
    .valid_o    (q_valid),
    .cmd_o      (cmd_out),
    .full_o     (q_full),
    .hit_o      (q_hit)
  );

  pktq_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .PKT_BYTES (PKT_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .valid_i     (q_valid),
    .cmd_i       (cmd_out),
    .deq_o       (deq),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

  a_no_enq_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq |-> !q_full)
    else $error("command queued while queue full");

  a_no_write_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> !q_hit)
    else $error("byte write into slot with pending read");

  a_result_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(q_valid))
    else $error("result without a queued command");

  a_final_dequeues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.final_res) |-> $past(deq))
    else $error("final result without dequeue");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_ring_queue_unit. A directed table covers the
// empty, zero-length, saturation, full-reject and discard cases, then random
// packet traffic runs under several slot counts. Every result is checked
// against an in-bench model of the ring, or for typed rows the table's result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pktq_pkg::*;

  localparam int MAX_SLOTS    = DEF_MAX_SLOTS;
  localparam int PKT_BYTES    = DEF_PKT_BYTES;
  localparam int DRAIN_CYCLES = 8;
  localparam int SPLIT_ROW    = 15;
  localparam int PHASE_ITEMS  = 22;

  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;

  typedef logic [$clog2(MAX_SLOTS)-1:0] idx_t;

  typedef struct {
    pktq_item_t item;
    int         reps;
    bit         last_each;
    bit         typed;
    pktq_res_t  want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pktq_item_t  req_item;
  logic        res_valid;
  pktq_res_t   dut_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // ring model
  logic [7:0] ring_data [MAX_SLOTS][PKT_BYTES];
  logic [4:0] ring_len  [MAX_SLOTS];
  idx_t       head_q;
  idx_t       tail_q;
  bit         full_q;
  bit         rejecting;
  logic [4:0] fill_cnt;
  logic [3:0] slots_reg;

  pktq_res_t ring_replies_due[$];
  dir_row_t  dir_rows[$];
  pktq_res_t want_q;

  int burst_left;
  int n_reqs;
  int n_checked;
  int n_cfg;
  int n_bad;

  packet_ring_queue_unit #(
    .MAX_SLOTS(MAX_SLOTS),
    .PKT_BYTES(PKT_BYTES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (req_item),
    .result_valid_o(res_valid),
    .result_o      (dut_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void note_bad(string msg);
    n_bad++;
    if (n_bad <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic string res_str(pktq_res_t r);
    return $sformatf("kind=%0d byte=%02h len=%0d depth=%0d status=%0d final=%0d",
                     r.result_kind, r.byte_out, r.length, r.depth, r.status, r.final_res);
  endfunction

  function automatic int ring_slots();
    if (slots_reg == 4'd0) return 1;
    if (int'(slots_reg) > MAX_SLOTS) return MAX_SLOTS;
    return int'(slots_reg);
  endfunction

  function automatic int packets_held();
    int n;
    n = ring_slots();
    if (full_q) return n;
    return (int'(head_q) + n - int'(tail_q)) % n;
  endfunction

  function automatic idx_t ring_next(idx_t idx);
    return (int'(idx) + 1 >= ring_slots()) ? '0 : idx + 1'b1;
  endfunction

  // writing the slot count empties the ring and drops a partial packet
  function automatic void load_slots(logic [3:0] val);
    slots_reg = val;
    head_q    = '0;
    tail_q    = '0;
    full_q    = 1'b0;
    fill_cnt  = '0;
    rejecting = 1'b0;
  endfunction

  function automatic void predict_ring_op(pktq_item_t it);
    pktq_res_t r;
    int        len;
    int        i;
    r             = '0;
    r.result_kind = it.mode;
    r.final_res   = 1'b1;
    case (it.mode)
      MODE_PUSH: begin
        // full flag only matters before the first byte is stored
        if (fill_cnt == 0 && !rejecting && full_q) rejecting = 1'b1;
        if (!rejecting && it.has_byte && fill_cnt < PKT_BYTES) begin
          ring_data[head_q][fill_cnt] = it.data_byte;
          fill_cnt++;
        end
        if (it.last) begin
          if (rejecting) begin
            r.status = 1'b1;
          end else begin
            ring_len[head_q] = fill_cnt;
            r.length         = fill_cnt;
            head_q           = ring_next(head_q);
            if (head_q == tail_q) full_q = 1'b1;
          end
          fill_cnt  = '0;
          rejecting = 1'b0;
          ring_replies_due.push_back(r);
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (packets_held() == 0) begin
          r.status = 1'b1;
          ring_replies_due.push_back(r);
        end else begin
          len = int'(ring_len[tail_q]);
          if (len > PKT_BYTES) len = PKT_BYTES;
          if (int'(it.max_len) < len) len = int'(it.max_len);
          if (len == 0) ring_replies_due.push_back(r);
          for (i = 0; i < len; i++) begin
            r.byte_out  = ring_data[tail_q][i];
            r.length    = 5'(len);
            r.final_res = (i == len - 1);
            ring_replies_due.push_back(r);
          end
          if (it.mode == MODE_POP) begin
            tail_q = ring_next(tail_q);
            full_q = 1'b0;
          end
        end
      end
      MODE_DROP: begin
        if (packets_held() == 0) begin
          r.status = 1'b1;
        end else begin
          tail_q = ring_next(tail_q);
          full_q = 1'b0;
        end
        ring_replies_due.push_back(r);
      end
      MODE_QUERY: begin
        r.depth = 4'(packets_held());
        ring_replies_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] mode, logic [7:0] data, bit has, bit last,
                                      logic [7:0] mlen, int reps, bit each, bit typed,
                                      logic [4:0] len, logic [3:0] dep, bit st);
    dir_row_t r;
    r.item.mode       = mode;
    r.item.data_byte  = data;
    r.item.has_byte   = has;
    r.item.last       = last;
    r.item.max_len    = mlen;
    r.reps            = reps;
    r.last_each       = each;
    r.typed           = typed;
    r.want            = '0;
    r.want.result_kind = mode;
    r.want.length     = len;
    r.want.depth      = dep;
    r.want.status     = st;
    r.want.final_res  = 1'b1;
    return r;
  endfunction

  // one request, with burst/gap pacing on the sender side
  task automatic send_item(input pktq_item_t it, output int n_new);
    int gap;
    int n_old;
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    burst_left--;
    start    <= 1'b1;
    req_item <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    n_old = ring_replies_due.size();
    predict_ring_op(it);
    n_new = ring_replies_due.size() - n_old;
    if (it.mode <= MODE_QUERY) n_reqs++;
  endtask

  task automatic set_slots(input logic [3:0] val);
    start <= 1'b0;
    while (ring_replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SLOTS_IN_USE;
    pwdata  <= {28'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    load_slots(val);
    n_cfg++;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[3:0] !== val)
      note_bad($sformatf("slot count readback %0h, wrote %0h", prdata[3:0], val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(input int quota);
    int         cnt;
    int         sel;
    int         nb;
    int         k;
    int         n_new;
    pktq_item_t it;
    cnt = 0;
    while (cnt < quota) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // well-formed packet, mostly short, now and then past the slot size
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
        for (k = 0; k < nb; k++) begin
          it          = pktq_item_t'($urandom);
          it.mode     = MODE_PUSH;
          it.has_byte = ($urandom_range(0, 9) != 0);
          it.last     = (k == nb - 1);
          send_item(it, n_new);
          cnt++;
        end
      end else begin
        it = pktq_item_t'($urandom);
        if (sel < 60)      it.mode = MODE_POP;
        else if (sel < 72) it.mode = MODE_PEEK;
        else if (sel < 80) it.mode = MODE_DROP;
        else if (sel < 88) it.mode = MODE_QUERY;
        else if (sel < 93) it.mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
        // otherwise raw noise, including stray push bytes
        if (sel < 72) begin
          case ($urandom_range(0, 9))
            0, 1:    it.max_len = 8'($urandom_range(0, 3));
            2, 3, 4: it.max_len = 8'($urandom);
            default: it.max_len = 8'hFF;
          endcase
        end
        send_item(it, n_new);
        if (it.mode <= MODE_QUERY) cnt++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid === 1'b1) begin
      if (ring_replies_due.size() == 0) begin
        note_bad($sformatf("result with none expected: %s", res_str(dut_res)));
      end else begin
        want_q = ring_replies_due.pop_front();
        n_checked++;
        if (dut_res.result_kind !== want_q.result_kind || dut_res.byte_out !== want_q.byte_out ||
            dut_res.length !== want_q.length || dut_res.depth !== want_q.depth ||
            dut_res.status !== want_q.status || dut_res.final_res !== want_q.final_res)
          note_bad($sformatf("expected %s, got %s", res_str(want_q), res_str(dut_res)));
      end
    end
  end

  initial begin
    #500_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [3:0] phase_slots [7];
    pktq_item_t it;
    int         i;
    int         k;
    int         w;
    int         n_new;

    rst_ni     = 1'b0;
    start      = 1'b0;
    req_item   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    n_reqs     = 0;
    n_checked  = 0;
    n_cfg      = 0;
    n_bad      = 0;
    load_slots(SLOTS_IN_USE_RST);
    phase_slots = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5};

    // empty ring at reset
    dir_rows.push_back(mk_row(MODE_QUERY, 8'h00, 0, 0, 8'h00, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_POP,   8'h00, 0, 0, 8'hFF, 1, 0, 1, 5'd0, 4'd0, 1'b1));
    dir_rows.push_back(mk_row(MODE_PEEK,  8'h00, 0, 0, 8'hFF, 1, 0, 1, 5'd0, 4'd0, 1'b1));
    dir_rows.push_back(mk_row(MODE_DROP,  8'h00, 0, 0, 8'hFF, 1, 0, 1, 5'd0, 4'd0, 1'b1));
    // empty packet, then zero-length peek and pop
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h00, 0, 1, 8'h00, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PEEK,  8'h00, 0, 0, 8'hFF, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_POP,   8'h00, 0, 0, 8'hFF, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    // 17 bytes offered, length saturates
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h00, 1, 0, 8'h00, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PUSH,  8'hFF, 1, 0, 8'hFF, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h3C, 0, 0, 8'h00, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h80, 1, 1, 8'h00, 15, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PEEK,  8'h00, 0, 0, 8'h00, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PEEK,  8'h00, 0, 0, 8'h03, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_POP,   8'h00, 0, 0, 8'hFF, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    // partial packet, discarded by the slot count write ahead of SPLIT_ROW
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h44, 1, 0, 8'h00, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_QUERY, 8'h00, 0, 0, 8'h00, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    // two slots: fill, reject a packet while full, drop, read back
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h01, 1, 1, 8'h00, 2, 1, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_QUERY, 8'h00, 0, 0, 8'h00, 1, 0, 1, 5'd0, 4'd2, 1'b0));
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h55, 1, 0, 8'h00, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PUSH,  8'h66, 1, 1, 8'h00, 1, 0, 1, 5'd0, 4'd0, 1'b1));
    dir_rows.push_back(mk_row(MODE_DROP,  8'h00, 0, 0, 8'h00, 1, 0, 1, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_RSVD_LO, 8'hAA, 1, 1, 8'hFF, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_RSVD_HI, 8'h55, 1, 1, 8'hFF, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_PEEK,  8'h00, 0, 0, 8'hFF, 1, 0, 0, 5'd0, 4'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_POP,   8'h00, 0, 0, 8'h01, 1, 0, 0, 5'd0, 4'd0, 1'b0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (i = 0; i < dir_rows.size(); i++) begin
      if (i == SPLIT_ROW) set_slots(4'd2);
      for (k = 0; k < dir_rows[i].reps; k++) begin
        it           = dir_rows[i].item;
        it.data_byte = dir_rows[i].item.data_byte + 8'(k);
        if (!dir_rows[i].last_each) it.last = it.last && (k == dir_rows[i].reps - 1);
        send_item(it, n_new);
        if (dir_rows[i].typed) begin
          repeat (n_new) void'(ring_replies_due.pop_back());
          ring_replies_due.push_back(dir_rows[i].want);
        end
      end
    end

    foreach (phase_slots[ph]) begin
      set_slots(phase_slots[ph]);
      random_phase(PHASE_ITEMS);
    end

    start <= 1'b0;
    for (w = 0; w < 5000 && ring_replies_due.size() != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ring_replies_due.size() != 0)
      note_bad($sformatf("%0d expected results never arrived", ring_replies_due.size()));

    $display("Ran %0d requests under %0d slot-count writes, %0d results compared.",
             n_reqs, n_cfg, n_checked);
    $display("Mismatches seen: %0d", n_bad);
    if (n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
